// ===== hdl/pinnable_lru_mru_cache_table_assert.svh =====
// Assertion macros for the pinnable cache table.
// Used by the datapath; needs signals named clock and reset in scope.
`ifndef PINNABLE_LRU_MRU_CACHE_TABLE_ASSERT_SVH
`define PINNABLE_LRU_MRU_CACHE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLMCT_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("plmct invariant violated");
`define PLMCT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plmct implication violated");
`else
`define PLMCT_ASSERT(label, cond)
`define PLMCT_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ===== hdl/plmct_pkg.sv =====
// Package for the pinnable cache table: sizes, codes and control types.
// No dependencies.
package plmct_pkg;
   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;
   localparam int PIN_BITS  = 8;
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int CAP_BITS  = 5;
   localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_CONTAINS = 3'd2,
      OP_RETAIN   = 3'd3,
      OP_RELEASE  = 3'd4,
      OP_CLEAR    = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PINNED    = 3'd2,
      ST_NO_VICTIM = 3'd3,
      ST_DUPLICATE = 3'd4,
      ST_CLEAR_REF = 3'd5,
      ST_PIN_ERROR = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      CSR_POLICY   = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
   } cmd_type;
endpackage

// ===== hdl/plmct_if.sv =====
// Channel interfaces for the pinnable cache table: request, response, csr.
// Depends on plmct_pkg.
interface plmct_req_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     opcode;
   logic [plmct_pkg::KEY_BITS-1:0]  key;
   logic [plmct_pkg::DATA_BITS-1:0] write_data;
   modport source (output valid, opcode, key, write_data, input ready);
   modport sink (input valid, opcode, key, write_data, output ready);
endinterface

interface plmct_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     status;
   logic                           hit;
   logic [plmct_pkg::DATA_BITS-1:0] read_data;
   logic                           evicted_valid;
   logic [plmct_pkg::KEY_BITS-1:0]  evicted_key;
   logic [plmct_pkg::DATA_BITS-1:0] evicted_data;
   modport source (output valid, status, hit, read_data, evicted_valid, evicted_key,
                   evicted_data, input ready);
   modport sink (input valid, status, hit, read_data, evicted_valid, evicted_key,
                 evicted_data, output ready);
endinterface

interface plmct_csr_if;
   logic                          valid;
   logic                          ready;
   logic [0:0]                    index;
   logic [plmct_pkg::CAP_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/plmct_ctrl.sv =====
// Controller for the pinnable cache table: sequences capture, lookup,
// execute and response. Depends on plmct_pkg.
module plmct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output plmct_pkg::cmd_type cmd
);
   typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_RESP} state_type;
   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_LOOK;
            S_LOOK: state_ff <= S_EXEC;
            S_EXEC: state_ff <= S_RESP;
            S_RESP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = req_valid && (state_ff == S_IDLE);
   assign cmd.lookup  = (state_ff == S_LOOK);
   assign cmd.execute = (state_ff == S_EXEC);
endmodule

// ===== hdl/plmct_dpath.sv =====
// Datapath for the pinnable cache table: entry store, recency ranks,
// lookup registers and result registers. Depends on plmct_pkg and the macros.
`include "pinnable_lru_mru_cache_table_assert.svh"
module plmct_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  plmct_pkg::cmd_type               cmd,
   input  logic [2:0]                       req_opcode,
   input  logic [plmct_pkg::KEY_BITS-1:0]   req_key,
   input  logic [plmct_pkg::DATA_BITS-1:0]  req_write_data,
   input  logic                             csr_write,
   input  logic [0:0]                       csr_index,
   input  logic [plmct_pkg::CAP_BITS-1:0]   csr_data,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_hit,
   output logic [plmct_pkg::DATA_BITS-1:0]  rsp_read_data,
   output logic                             rsp_evicted_valid,
   output logic [plmct_pkg::KEY_BITS-1:0]   rsp_evicted_key,
   output logic [plmct_pkg::DATA_BITS-1:0]  rsp_evicted_data
);
   localparam int E  = plmct_pkg::ENTRIES;
   localparam int IB = plmct_pkg::IDX_BITS;
   localparam int CB = plmct_pkg::CNT_BITS;
   localparam int MB = plmct_pkg::CMP_BITS;
   localparam int PB = plmct_pkg::PIN_BITS;
   localparam int KB = plmct_pkg::KEY_BITS;
   localparam int DB = plmct_pkg::DATA_BITS;
   localparam logic [PB-1:0] PIN_MAX = {PB{1'b1}};

   plmct_pkg::opcode_type op_ff;
   logic [KB-1:0] key_ff;
   logic [DB-1:0] wdata_ff;
   logic          policy_ff;
   logic [plmct_pkg::CAP_BITS-1:0] capacity_ff;

   logic [E-1:0]  valid_ff, valid_in;
   logic [KB-1:0] ekey_ff [E];
   logic [KB-1:0] ekey_in [E];
   logic [DB-1:0] edata_ff [E];
   logic [DB-1:0] edata_in [E];
   logic [PB-1:0] pin_ff [E];
   logic [PB-1:0] pin_in [E];
   logic [IB-1:0] rank_ff [E];
   logic [IB-1:0] rank_in [E];
   logic [CB-1:0] entry_count_ff, entry_count_in;
   logic [CB-1:0] unpinned_count_ff, unpinned_count_in;

   logic [E-1:0] match_ff, victim_ff, match_c, victim_c, order_c;
   logic         victim_found_ff, full_ff, any_pinned_ff;
   logic         victim_found_c, any_pinned_c, full_c;
   logic [MB-1:0] cap_c;
   logic [IB-1:0] target_c;

   logic [2:0]    status_ff, status_in;
   logic          hit_ff, hit_in;
   logic [DB-1:0] rdata_ff, rdata_in;
   logic          ev_ff, ev_in;
   logic [KB-1:0] evkey_ff, evkey_in;
   logic [DB-1:0] evdata_ff, evdata_in;

   // lookup stage
   always_comb begin
      if (capacity_ff == '0)
         cap_c = MB'(1);
      else if (MB'(capacity_ff) > MB'(E))
         cap_c = MB'(E);
      else
         cap_c = MB'(capacity_ff);
      full_c = (MB'(entry_count_ff) >= cap_c);
      target_c = policy_ff ? '0 : IB'(unpinned_count_ff - CB'(1));
      victim_found_c = 1'b0;
      any_pinned_c = 1'b0;
      for (int j = 0; j < E; j++) begin
         match_c[j]  = valid_ff[j] && (ekey_ff[j] == key_ff);
         order_c[j]  = valid_ff[j] && (pin_ff[j] == '0);
         victim_c[j] = 1'b0;
         if (valid_ff[j] && pin_ff[j] != '0) any_pinned_c = 1'b1;
         if (order_c[j] && rank_ff[j] == target_c && !victim_found_c) begin
            victim_c[j] = 1'b1;
            victim_found_c = 1'b1;
         end
      end
   end

   // execute stage
   logic [IB-1:0] m_idx, v_idx, f_idx;
   logic [E-1:0]  free_mask;
   logic          free_found, evict;
   logic [IB-1:0] rank_ref;
   always_comb begin
      m_idx = '0;
      v_idx = '0;
      f_idx = '0;
      free_found = 1'b0;
      evict = 1'b0;
      for (int j = 0; j < E; j++) begin
         if (match_ff[j])  m_idx = m_idx | IB'(j);
         if (victim_ff[j]) v_idx = v_idx | IB'(j);
      end
      rank_ref = rank_ff[m_idx];
      valid_in = valid_ff;
      ekey_in = ekey_ff;
      edata_in = edata_ff;
      pin_in = pin_ff;
      rank_in = rank_ff;
      entry_count_in = entry_count_ff;
      unpinned_count_in = unpinned_count_ff;
      status_in = plmct_pkg::ST_OK;
      hit_in = 1'b0;
      rdata_in = '0;
      ev_in = 1'b0;
      evkey_in = '0;
      evdata_in = '0;
      free_mask = '0;
      unique case (op_ff)
         plmct_pkg::OP_INSERT: begin
            if (match_ff != '0) begin
               status_in = plmct_pkg::ST_DUPLICATE;
               hit_in = 1'b1;
            end else if (full_ff && (unpinned_count_ff == '0 || !victim_found_ff)) begin
               status_in = plmct_pkg::ST_NO_VICTIM;
            end else begin
               evict = full_ff;
               free_mask = ~valid_ff | (evict ? victim_ff : '0);
               for (int j = 0; j < E; j++) begin
                  if (free_mask[j] && !free_found) begin
                     f_idx = IB'(j);
                     free_found = 1'b1;
                  end
               end
               if (!free_found) begin
                  status_in = plmct_pkg::ST_NO_VICTIM;
               end else begin
                  if (evict) begin
                     ev_in = 1'b1;
                     evkey_in = ekey_ff[v_idx];
                     evdata_in = edata_ff[v_idx];
                     valid_in[v_idx] = 1'b0;
                  end
                  for (int j = 0; j < E; j++) begin
                     if (order_c[j] && !(evict && victim_ff[j]))
                        rank_in[j] = rank_ff[j] + IB'(1)
                           - IB'(evict && rank_ff[j] > rank_ff[v_idx]);
                  end
                  ekey_in[f_idx] = key_ff;
                  edata_in[f_idx] = wdata_ff;
                  pin_in[f_idx] = '0;
                  rank_in[f_idx] = '0;
                  valid_in[f_idx] = 1'b1;
                  if (!evict) begin
                     entry_count_in = entry_count_ff + CB'(1);
                     unpinned_count_in = unpinned_count_ff + CB'(1);
                  end
               end
            end
         end
         plmct_pkg::OP_REMOVE: begin
            if (match_ff == '0) begin
               status_in = plmct_pkg::ST_NOT_FOUND;
            end else if (pin_ff[m_idx] != '0) begin
               status_in = plmct_pkg::ST_PINNED;
               hit_in = 1'b1;
            end else begin
               hit_in = 1'b1;
               ev_in = 1'b1;
               evkey_in = ekey_ff[m_idx];
               evdata_in = edata_ff[m_idx];
               for (int j = 0; j < E; j++) begin
                  if (order_c[j] && !match_ff[j] && rank_ff[j] > rank_ref)
                     rank_in[j] = rank_ff[j] - IB'(1);
               end
               valid_in[m_idx] = 1'b0;
               if (unpinned_count_ff != '0) unpinned_count_in = unpinned_count_ff - CB'(1);
               if (entry_count_ff != '0) entry_count_in = entry_count_ff - CB'(1);
            end
         end
         plmct_pkg::OP_CONTAINS: begin
            if (match_ff == '0) status_in = plmct_pkg::ST_NOT_FOUND;
            else hit_in = 1'b1;
         end
         plmct_pkg::OP_RETAIN: begin
            if (match_ff == '0) begin
               status_in = plmct_pkg::ST_NOT_FOUND;
            end else if (pin_ff[m_idx] == PIN_MAX) begin
               status_in = plmct_pkg::ST_PIN_ERROR;
               hit_in = 1'b1;
            end else begin
               hit_in = 1'b1;
               if (pin_ff[m_idx] == '0) begin
                  for (int j = 0; j < E; j++) begin
                     if (order_c[j] && !match_ff[j] && rank_ff[j] > rank_ref)
                        rank_in[j] = rank_ff[j] - IB'(1);
                  end
                  if (unpinned_count_ff != '0)
                     unpinned_count_in = unpinned_count_ff - CB'(1);
               end
               pin_in[m_idx] = pin_ff[m_idx] + PB'(1);
               rdata_in = edata_ff[m_idx];
            end
         end
         plmct_pkg::OP_RELEASE: begin
            if (match_ff == '0) begin
               status_in = plmct_pkg::ST_NOT_FOUND;
            end else if (pin_ff[m_idx] == '0) begin
               status_in = plmct_pkg::ST_PIN_ERROR;
               hit_in = 1'b1;
            end else begin
               hit_in = 1'b1;
               pin_in[m_idx] = pin_ff[m_idx] - PB'(1);
               if (pin_ff[m_idx] == PB'(1)) begin
                  for (int j = 0; j < E; j++) begin
                     if (order_c[j]) rank_in[j] = rank_ff[j] + IB'(1);
                  end
                  rank_in[m_idx] = '0;
                  unpinned_count_in = unpinned_count_ff + CB'(1);
               end
            end
         end
         plmct_pkg::OP_CLEAR: begin
            if (any_pinned_ff) begin
               status_in = plmct_pkg::ST_CLEAR_REF;
            end else begin
               valid_in = '0;
               entry_count_in = '0;
               unpinned_count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         entry_count_ff <= '0;
         unpinned_count_ff <= '0;
         policy_ff <= 1'b0;
         capacity_ff <= plmct_pkg::CAP_BITS'(16);
      end else begin
         if (csr_write) begin
            unique case (plmct_pkg::csr_index_type'(csr_index))
               plmct_pkg::CSR_POLICY:   policy_ff <= csr_data[0];
               plmct_pkg::CSR_CAPACITY: capacity_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.execute) begin
            valid_ff <= valid_in;
            entry_count_ff <= entry_count_in;
            unpinned_count_ff <= unpinned_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= plmct_pkg::opcode_type'(req_opcode);
         key_ff <= req_key;
         wdata_ff <= req_write_data;
      end
      if (cmd.lookup) begin
         match_ff <= match_c;
         victim_ff <= victim_c;
         victim_found_ff <= victim_found_c;
         full_ff <= full_c;
         any_pinned_ff <= any_pinned_c;
      end
      if (cmd.execute) begin
         ekey_ff <= ekey_in;
         edata_ff <= edata_in;
         pin_ff <= pin_in;
         rank_ff <= rank_in;
         status_ff <= status_in;
         hit_ff <= hit_in;
         rdata_ff <= rdata_in;
         ev_ff <= ev_in;
         evkey_ff <= evkey_in;
         evdata_ff <= evdata_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_hit = hit_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_evicted_valid = ev_ff;
   assign rsp_evicted_key = evkey_ff;
   assign rsp_evicted_data = evdata_ff;

   `PLMCT_ASSERT(a_count_matches_valid, $countones(valid_ff) == 32'(entry_count_ff))
   `PLMCT_ASSERT(a_unpinned_le_count, unpinned_count_ff <= entry_count_ff)
   `PLMCT_ASSERT_IMP(a_evict_only_ins_rem, cmd.execute && ev_in, op_ff == plmct_pkg::OP_INSERT || op_ff == plmct_pkg::OP_REMOVE)
endmodule

// ===== hdl/pinnable_lru_mru_cache_table.sv =====
// Pinnable LRU/MRU key/data cache table, top level.
// The response is registered: a request is captured, looked up, then executed into
// the result registers, and the response is held valid until it is taken.
// One item at a time (accept, lookup, execute, response): a new request is accepted
// only after the previous response is taken.
// Synchronous active-high reset empties the table, policy LRU, capacity 16.
module pinnable_lru_mru_cache_table (
   input  logic clock,
   input  logic reset,
   plmct_req_if.sink   req_bus,
   plmct_rsp_if.source rsp_bus,
   plmct_csr_if.sink   csr_bus
);
   plmct_pkg::cmd_type cmd;

   assign csr_bus.ready = 1'b1;

   plmct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   plmct_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_bus.opcode),
      .req_key           (req_bus.key),
      .req_write_data    (req_bus.write_data),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_status        (rsp_bus.status),
      .rsp_hit           (rsp_bus.hit),
      .rsp_read_data     (rsp_bus.read_data),
      .rsp_evicted_valid (rsp_bus.evicted_valid),
      .rsp_evicted_key   (rsp_bus.evicted_key),
      .rsp_evicted_data  (rsp_bus.evicted_data)
   );
endmodule

// ===== tb/tb_plmct_if.sv =====
// Testbench copy of the cache table channel interfaces is not needed; the RTL
// interfaces in plmct_if.sv are used directly. This file holds the scoreboard.
// Depends on plmct_pkg.
`timescale 1ns / 100ps
package tb_plmct_sb_pkg;
   import plmct_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [31:0] read_data;
      logic        evicted_valid;
      logic [31:0] evicted_key;
      logic [31:0] evicted_data;
   } cache_rsp_t;

   class cache_table_scoreboard;
      bit          slot_used[ENTRIES];
      logic [31:0] slot_key[ENTRIES];
      logic [31:0] slot_data[ENTRIES];
      int          slot_pins[ENTRIES];
      int          slot_rank[ENTRIES];
      int          used_count;
      int          free_order;
      bit          mru_mode;
      int          cap_reg;
      cache_rsp_t  pending_q[$];
      int          mismatches;

      function new();
         foreach (slot_used[i]) slot_used[i] = 0;
         used_count = 0;
         free_order = 0;
         mru_mode = 0;
         cap_reg = 16;
         mismatches = 0;
      endfunction

      function bit ordered(int i);
         return slot_used[i] && slot_pins[i] == 0;
      endfunction

      function void unlink(int i);
         foreach (slot_used[j])
            if (j != i && ordered(j) && slot_rank[j] > slot_rank[i]) slot_rank[j]--;
         if (free_order > 0) free_order--;
      endfunction

      function void to_head(int i);
         foreach (slot_used[j])
            if (j != i && ordered(j)) slot_rank[j]++;
         slot_rank[i] = 0;
         free_order++;
      endfunction

      function void set_csr(bit idx, logic [4:0] val);
         if (idx == CSR_POLICY) mru_mode = val[0];
         else cap_reg = val;
      endfunction

      function void note_request(logic [2:0] op, logic [31:0] key, logic [31:0] wd);
         cache_rsp_t r;
         int hit_idx, cap, victim, target, j;
         r = '0;
         cap = cap_reg < 1 ? 1 : (cap_reg > ENTRIES ? ENTRIES : cap_reg);
         hit_idx = -1;
         for (int k = 0; k < ENTRIES; k++)
            if (hit_idx < 0 && slot_used[k] && slot_key[k] == key) hit_idx = k;
         case (op)
            OP_INSERT: begin
               if (hit_idx >= 0) begin
                  r.status = ST_DUPLICATE;
                  r.hit = 1;
               end else begin
                  victim = -2;
                  if (used_count >= cap) begin
                     victim = -1;
                     if (free_order > 0) begin
                        target = mru_mode ? 0 : free_order - 1;
                        for (int k = 0; k < ENTRIES; k++)
                           if (victim < 0 && ordered(k) && slot_rank[k] == target) victim = k;
                     end
                     if (victim < 0) r.status = ST_NO_VICTIM;
                     else begin
                        r.evicted_valid = 1;
                        r.evicted_key = slot_key[victim];
                        r.evicted_data = slot_data[victim];
                        unlink(victim);
                        slot_used[victim] = 0;
                        if (used_count > 0) used_count--;
                     end
                  end
                  if (victim != -1) begin
                     j = -1;
                     for (int k = 0; k < ENTRIES; k++)
                        if (j < 0 && !slot_used[k]) j = k;
                     if (j < 0) r.status = ST_NO_VICTIM;
                     else begin
                        slot_key[j] = key;
                        slot_data[j] = wd;
                        slot_pins[j] = 0;
                        to_head(j);
                        slot_used[j] = 1;
                        used_count++;
                     end
                  end
               end
            end
            OP_REMOVE: begin
               if (hit_idx < 0) r.status = ST_NOT_FOUND;
               else begin
                  r.hit = 1;
                  if (slot_pins[hit_idx] != 0) r.status = ST_PINNED;
                  else begin
                     r.evicted_valid = 1;
                     r.evicted_key = slot_key[hit_idx];
                     r.evicted_data = slot_data[hit_idx];
                     unlink(hit_idx);
                     slot_used[hit_idx] = 0;
                     if (used_count > 0) used_count--;
                  end
               end
            end
            OP_CONTAINS: begin
               if (hit_idx < 0) r.status = ST_NOT_FOUND;
               else r.hit = 1;
            end
            OP_RETAIN: begin
               if (hit_idx < 0) r.status = ST_NOT_FOUND;
               else begin
                  r.hit = 1;
                  if (slot_pins[hit_idx] >= 255) r.status = ST_PIN_ERROR;
                  else begin
                     if (slot_pins[hit_idx] == 0) unlink(hit_idx);
                     slot_pins[hit_idx]++;
                     r.read_data = slot_data[hit_idx];
                  end
               end
            end
            OP_RELEASE: begin
               if (hit_idx < 0) r.status = ST_NOT_FOUND;
               else begin
                  r.hit = 1;
                  if (slot_pins[hit_idx] == 0) r.status = ST_PIN_ERROR;
                  else begin
                     slot_pins[hit_idx]--;
                     if (slot_pins[hit_idx] == 0) begin
                        slot_used[hit_idx] = 0;
                        to_head(hit_idx);
                        slot_used[hit_idx] = 1;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               j = 0;
               foreach (slot_used[k]) if (slot_used[k] && slot_pins[k] != 0) j = 1;
               if (j) r.status = ST_CLEAR_REF;
               else begin
                  foreach (slot_used[k]) slot_used[k] = 0;
                  used_count = 0;
                  free_order = 0;
               end
            end
            default: ;
         endcase
         pending_q.push_back(r);
      endfunction

      function void check_response(cache_rsp_t got);
         cache_rsp_t exp;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         exp = pending_q.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
         end
      endfunction
   endclass
endpackage

// ===== tb/tb_pinnable_lru_mru_cache_table.sv =====
// Testbench for pinnable_lru_mru_cache_table: directed and random requests,
// checked against a scoreboard predictor. Depends on plmct_pkg, plmct_if, tb_plmct_sb_pkg.
`timescale 1ns / 100ps
module tb_pinnable_lru_mru_cache_table;
   import plmct_pkg::*;
   import tb_plmct_sb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   cycle_count = 0;
   bit   stim_done = 0;
   cache_table_scoreboard table_model = new();
   logic [31:0] key_pool[8];

   plmct_req_if req_bus();
   plmct_rsp_if rsp_bus();
   plmct_csr_if csr_bus();

   pinnable_lru_mru_cache_table u_dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_request(logic [2:0] op, logic [31:0] key, logic [31:0] wd);
      int gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.opcode <= op;
      req_bus.key <= key;
      req_bus.write_data <= wd;
      do @(posedge clock); while (!req_bus.ready);
      table_model.note_request(op, key, wd);
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_bus.valid <= 0;
   endtask

   task automatic write_csr(bit idx, logic [4:0] val);
      drop_request();
      while (table_model.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      table_model.set_csr(idx, val);
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   function automatic logic [31:0] pool_key();
      return key_pool[$urandom_range(0, 7)];
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         table_model.check_response({rsp_bus.status, rsp_bus.hit, rsp_bus.read_data,
            rsp_bus.evicted_valid, rsp_bus.evicted_key, rsp_bus.evicted_data});
   end

   always @(negedge clock) begin
      if (!stim_done && $urandom_range(0, 29) == 0) rsp_bus.ready <= 0;
      else if (!rsp_bus.ready && $urandom_range(0, 2) == 0) rsp_bus.ready <= 1;
      else if (stim_done) rsp_bus.ready <= 1;
   end

   initial begin
      int sel;
      logic [31:0] k;
      req_bus.valid = 0;
      req_bus.opcode = OP_INSERT;
      req_bus.key = '0;
      req_bus.write_data = '0;
      rsp_bus.ready = 1;
      csr_bus.valid = 0;
      csr_bus.index = CSR_POLICY;
      csr_bus.data = '0;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int n = 2; n < 8; n++) key_pool[n] = $urandom;
      repeat (5) @(negedge clock);
      reset = 0;

      // directed: extremes, every operation, special cases
      send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'h0, 32'h1234);
      send_request(OP_CONTAINS, 32'h0, 0);
      send_request(OP_CONTAINS, 32'h5555_5555, 0);
      send_request(OP_RETAIN, 32'h0, 0);
      send_request(OP_REMOVE, 32'h0, 0);
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_RELEASE, 32'h0, 0);
      send_request(OP_RELEASE, 32'h0, 0);
      send_request(OP_RELEASE, 32'hFFFF_FFFF, 0);
      send_request(OP_RETAIN, 32'hAAAA_AAAA, 0);
      send_request(OP_REMOVE, 32'hAAAA_AAAA, 0);
      send_request(3'd6, 32'h1, 32'h1);
      send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      for (int n = 0; n < 256; n++) send_request(OP_RETAIN, 32'hFFFF_FFFF, 0);
      for (int n = 0; n < 255; n++) send_request(OP_RELEASE, 32'hFFFF_FFFF, 0);
      send_request(OP_CLEAR, 0, 0);

      for (int phase = 0; phase < 8; phase++) begin
         write_csr(CSR_POLICY, {4'b0, phase[0]});
         case (phase)
            0: write_csr(CSR_CAPACITY, 5'd16);
            1: write_csr(CSR_CAPACITY, 5'd1);
            2: write_csr(CSR_CAPACITY, 5'd0);
            3: write_csr(CSR_CAPACITY, 5'd31);
            4: write_csr(CSR_CAPACITY, 5'd3);
            default: write_csr(CSR_CAPACITY, 5'($urandom_range(1, 20)));
         endcase
         for (int n = 0; n < 65; n++) begin
            sel = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom : pool_key();
            if (sel < 40) send_request(OP_INSERT, k, $urandom);
            else if (sel < 52) send_request(OP_REMOVE, k, $urandom);
            else if (sel < 62) send_request(OP_CONTAINS, k, $urandom);
            else if (sel < 78) send_request(OP_RETAIN, k, $urandom);
            else if (sel < 94) send_request(OP_RELEASE, k, $urandom);
            else if (sel < 98) send_request(OP_CLEAR, k, $urandom);
            else send_request(3'($urandom_range(6, 7)), k, $urandom);
         end
      end
      drop_request();
      stim_done = 1;
      while (table_model.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (table_model.mismatches == 0 && table_model.pending_q.size() == 0)
         $display("tb_pinnable_lru_mru_cache_table: clean");
      else
         $display("tb_pinnable_lru_mru_cache_table: errors");
      $finish;
   end

   initial begin
      wait (cycle_count >= 400000);
      $display("tb_pinnable_lru_mru_cache_table: errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/plmct_pkg.sv
hdl/plmct_if.sv
hdl/plmct_ctrl.sv
hdl/plmct_dpath.sv
hdl/pinnable_lru_mru_cache_table.sv
tb/tb_plmct_if.sv
tb/tb_pinnable_lru_mru_cache_table.sv
